FILE: src/bfr_pkg.sv
// Shared types and constants for the byte frame receiver.
package bfr_pkg;

    // Parse phase of the frame receiver.
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CK_LO   = 3'd5,
        PH_CK_HI   = 3'd6,
        PH_END     = 3'd7
    } phase_t;

    // Frame status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_START    = 3'd1;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd2;
    localparam logic [2:0] ST_BAD_CHECKSUM = 3'd3;
    localparam logic [2:0] ST_BAD_END      = 3'd4;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD  = 2'd2;

    // Start marker, end marker, type, two length and two checksum bytes.
    localparam logic [15:0] FRAME_OVERHEAD = 16'd7;

    // One result item.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] msg_type;
        logic [7:0] pay_len;
        logic [2:0] status;
        logic       last;
    } result_t;

endpackage

FILE: src/bfr_parser.sv
// Frame parse state machine with running checksum and result generation.
module bfr_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       start_marker,
    input  logic [7:0]       end_marker,
    input  logic [7:0]       max_payload,
    output logic             res_valid,
    output bfr_pkg::result_t res
);
    import bfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;

    logic [15:0] total;
    logic [15:0] total_m7;
    logic        len_bad;
    logic [7:0]  count_inc;
    logic [15:0] sum_init;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            len_lo_reg <= '0;
            plen_reg   <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            ck_lo_reg  <= '0;
        end else begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            len_lo_reg <= len_lo_next;
            plen_reg   <= plen_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            ck_lo_reg  <= ck_lo_next;
        end
    end

    assign total     = {rx_byte, len_lo_reg};
    assign total_m7  = total - FRAME_OVERHEAD;
    assign len_bad   = (total < FRAME_OVERHEAD) || (total_m7 > {8'd0, max_payload});
    assign count_inc = count_reg + 8'd1;
    assign sum_init  = {8'd0, type_reg} + {8'd0, total_m7[7:0]}
                     + {8'd0, start_marker} + {8'd0, end_marker};

    always_comb begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        len_lo_next = len_lo_reg;
        plen_next   = plen_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        ck_lo_next  = ck_lo_reg;
        res_valid   = 1'b0;
        res         = '{kind: KIND_STATUS, data_byte: 8'd0, byte_index: 8'd0,
                        msg_type: type_reg, pay_len: plen_reg,
                        status: ST_OK, last: 1'b1};
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == start_marker) begin
                        phase_next = PH_TYPE;
                    end else begin
                        res_valid    = 1'b1;
                        res.msg_type = 8'd0;
                        res.pay_len  = 8'd0;
                        res.status   = ST_BAD_START;
                    end
                end
                PH_TYPE: begin
                    type_next  = rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len_lo_next = rx_byte;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    if (len_bad) begin
                        phase_next  = PH_HUNT;
                        res_valid   = 1'b1;
                        res.pay_len = 8'd0;
                        res.status  = ST_BAD_LENGTH;
                    end else begin
                        plen_next  = total_m7[7:0];
                        count_next = 8'd0;
                        sum_next   = sum_init;
                        phase_next = (total_m7[7:0] == 8'd0) ? PH_CK_LO : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_PAYLOAD;
                    res.data_byte  = rx_byte;
                    res.byte_index = count_reg;
                    res.status     = ST_OK;
                    res.last       = 1'b0;
                    sum_next       = sum_reg + {8'd0, rx_byte};
                    count_next     = count_inc;
                    if (count_inc >= plen_reg) begin
                        phase_next = PH_CK_LO;
                    end
                end
                PH_CK_LO: begin
                    ck_lo_next = rx_byte;
                    phase_next = PH_CK_HI;
                end
                PH_CK_HI: begin
                    if ({rx_byte, ck_lo_reg} != sum_reg) begin
                        phase_next = PH_HUNT;
                        res_valid  = 1'b1;
                        res.status = ST_BAD_CHECKSUM;
                    end else begin
                        phase_next = PH_END;
                    end
                end
                PH_END: begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res.status = (rx_byte == end_marker) ? ST_OK : ST_BAD_END;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

endmodule

FILE: src/bfr_out_reg.sv
// Result register between the parser and the result channel.
module bfr_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  bfr_pkg::result_t load_data,
    input  logic             out_ready,
    output logic             out_valid,
    output bfr_pkg::result_t out_data,
    output logic             can_load
);
    import bfr_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign can_load = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = load_data;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/byte_frame_receiver.sv
// Byte stream frame receiver with additive checksum check, top level.
// A payload byte or status result appears on the m_ side in the cycle after its input
// transfer. Throughput: one byte per cycle while s_ready is high, single parse stage.
// s_ready stays high while the result register is empty or is being drained this cycle.
// Reset (aresetn low at a clock edge) restores the default markers and maximum payload,
// returns the parser to hunting for a start marker and empties the result register.
module byte_frame_receiver (
    input  logic       aclk,
    input  logic       aresetn,
    // Input byte channel.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // Result channel.
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_kind,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_byte_index,
    output logic [7:0] m_msg_type,
    output logic [7:0] m_pay_len,
    output logic [2:0] m_status,
    output logic       m_last,
    // Configuration write channel.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import bfr_pkg::*;

    logic       start_wr;
    logic [7:0] start_reg, start_next;
    logic [7:0] end_reg, end_next;
    logic [7:0] max_reg, max_next;

    logic    in_accept;
    logic    res_valid;
    result_t res;
    result_t out_data;
    logic    can_load;

    // Configuration writes are always taken; an index beyond the register list is
    // dropped. Writes must only happen while the block is idle; nothing enforces this.
    assign cfg_ready = 1'b1;
    assign start_wr  = cfg_valid && (cfg_index == CFG_START_MARKER);

    always_comb begin
        start_next = start_reg;
        end_next   = end_reg;
        max_next   = max_reg;
        if (start_wr) begin
            start_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == CFG_END_MARKER)) begin
            end_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == CFG_MAX_PAYLOAD)) begin
            max_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 8'h4E;
            end_reg   <= 8'h56;
            max_reg   <= 8'hFF;
        end else begin
            start_reg <= start_next;
            end_reg   <= end_next;
            max_reg   <= max_next;
        end
    end

    // A byte is taken whenever the result register can take whatever it produces.
    // Every byte that arrives advances the parser; at most one result comes of it.
    assign s_ready   = can_load;
    assign in_accept = s_valid && s_ready;

    bfr_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (in_accept),
        .rx_byte      (s_rx_byte),
        .start_marker (start_reg),
        .end_marker   (end_reg),
        .max_payload  (max_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // The result register keeps a finished result until the downstream transfer; while
    // it waits, s_ready is low and the parser consumes no bytes.
    bfr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .can_load  (can_load)
    );

    assign m_kind       = out_data.kind;
    assign m_data_byte  = out_data.data_byte;
    assign m_byte_index = out_data.byte_index;
    assign m_msg_type   = out_data.msg_type;
    assign m_pay_len    = out_data.pay_len;
    assign m_status     = out_data.status;
    assign m_last       = out_data.last;

endmodule
